@@ src/btlpm_pkg.sv @@
// Shared types and constants for the binary trie longest-prefix-match block.
// No dependencies; imported by binary_trie_longest_prefix_match.
`default_nettype none

package btlpm_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned GW_BITS   = 32;
  localparam int unsigned PLEN_BITS = 6;
  localparam int unsigned OUT_BITS  = GW_BITS + 2;
  localparam int unsigned OUT_TW    = ((OUT_BITS + 7) / 8) * 8;

  // Operation carried in tuser.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CHECK,
    ST_EXTEND,
    ST_RESULT
  } state_e;

endpackage

`default_nettype wire

@@ src/binary_trie_longest_prefix_match.sv @@
// Route table kept as a binary trie in an on-chip node memory, with a walk sequencer.
// Depends on btlpm_pkg for field widths, operation codes and sequencer states.
//
// Usage:
//   The slave stream takes one command per transaction. tuser selects the
//   operation (0 insert, 1 lookup); tdata carries address, prefix length and
//   gateway. The master stream returns exactly one result per command with
//   next_hop, found and table_full.
//   A command walks the trie one level per cycle, reading one node from the
//   node memory (registered read) and following one address bit. A lookup
//   walks until every address bit is used or a child is missing, then returns
//   its result. An insert follows the existing levels down to its prefix
//   length, checks that the missing levels fit, links one new node per
//   missing level, stores the gateway in a final write and returns its
//   result. One command is in flight at a time; tready is high only while idle.
//   Results sit in an output register, so a new command is accepted while a
//   result waits; if the receiver still stalls when the next result is done,
//   the sequencer holds that result until the register frees.
//   Reset empties the table at once: the root lives in flip-flops that reset
//   clears, and every other node is written when it is allocated.
`default_nettype none

module binary_trie_longest_prefix_match #(
  parameter int unsigned NODE_COUNT = 1024,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  // Fields from bit 0 up: address, prefix_len, gateway, zero fill.
  input  wire logic [((ADDR_BITS + 38 + 7) / 8) * 8 - 1:0] s_axis_tdata_i,
  // Field: action.
  input  wire logic                                        s_axis_tuser_i,
  input  wire logic                                        s_axis_tvalid_i,
  output logic                                             s_axis_tready_o,
  // Fields from bit 0 up: next_hop, found, table_full, zero fill.
  output logic [btlpm_pkg::OUT_TW-1:0]                     m_axis_tdata_o,
  output logic                                             m_axis_tvalid_o,
  input  wire logic                                        m_axis_tready_i
);

  import btlpm_pkg::*;

  localparam int unsigned NW     = $clog2(NODE_COUNT);
  localparam int unsigned DW     = $clog2(ADDR_BITS + 1);
  localparam int unsigned FW     = NW + 1;
  localparam int unsigned SW     = NW + 2;
  localparam int unsigned NODE_W = 2 * NW + GW_BITS;

  // Node memory, written while an insert links nodes or stores its gateway, read once per walk step.
  logic [NODE_W-1:0] node_mem [NODE_COUNT];
  logic              rd_en;
  logic [NW-1:0]     rd_addr;
  logic [NODE_W-1:0] rdata_q;
  logic              wr_en;
  logic [NW-1:0]     wr_addr;
  logic [NODE_W-1:0] wr_data;

  // Root node held in flip-flops.
  logic [NW-1:0]      root_kid0_q, root_kid0_d;
  logic [NW-1:0]      root_kid1_q, root_kid1_d;
  logic [GW_BITS-1:0] root_ent_q, root_ent_d;

  // Sequencer state and working registers.
  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [DW-1:0]      len_q, len_d;
  logic [DW-1:0]      dep_q, dep_d;
  logic [NW-1:0]      cur_q, cur_d;
  logic               fresh_q, fresh_d;
  logic [GW_BITS-1:0] best_q, best_d;
  logic [GW_BITS-1:0] gw_q, gw_d;
  logic               full_q, full_d;
  logic [FW-1:0]      free_q, free_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [GW_BITS-1:0] out_hop_q, out_hop_d;
  logic               out_found_q, out_found_d;
  logic               out_full_q, out_full_d;

  // Input field views and working values.
  logic [ADDR_BITS-1:0] in_addr;
  logic [6:0]           in_plen;
  logic [GW_BITS-1:0]   in_gw;
  logic [NW-1:0]        view_kid0, view_kid1, child, fresh_idx;
  logic [GW_BITS-1:0]   view_ent;
  logic                 addr_bit;
  logic [SW-1:0]        need_total;
  logic                 out_load;

  assign in_addr = s_axis_tdata_i[ADDR_BITS-1:0];
  assign in_plen = {1'b0, s_axis_tdata_i[ADDR_BITS +: PLEN_BITS]};
  assign in_gw   = s_axis_tdata_i[ADDR_BITS + PLEN_BITS +: GW_BITS];

  // Current node contents: root flops, a freshly allocated (cleared) node, or memory data.
  always_comb begin
    if (cur_q == '0) begin
      view_kid0 = root_kid0_q;
      view_kid1 = root_kid1_q;
      view_ent  = root_ent_q;
    end else if (fresh_q) begin
      view_kid0 = '0;
      view_kid1 = '0;
      view_ent  = '0;
    end else begin
      view_kid0 = rdata_q[GW_BITS +: NW];
      view_kid1 = rdata_q[GW_BITS + NW +: NW];
      view_ent  = rdata_q[GW_BITS-1:0];
    end
  end

  assign addr_bit   = addr_q[ADDR_BITS-1];
  assign child      = addr_bit ? view_kid1 : view_kid0;
  assign fresh_idx  = free_q[NW-1:0];
  assign need_total = SW'(free_q) + SW'(len_q - dep_q);

  // Next state, node memory control and result formation.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    len_d       = len_q;
    dep_d       = dep_q;
    cur_d       = cur_q;
    fresh_d     = fresh_q;
    best_d      = best_q;
    gw_d        = gw_q;
    full_d      = full_q;
    free_d      = free_q;
    root_kid0_d = root_kid0_q;
    root_kid1_d = root_kid1_q;
    root_ent_d  = root_ent_q;
    rd_en       = 1'b0;
    rd_addr     = child;
    wr_en       = 1'b0;
    wr_addr     = cur_q;
    wr_data     = {view_kid1, view_kid0, view_ent};
    out_load    = 1'b0;
    out_hop_d   = out_hop_q;
    out_found_d = out_found_q;
    out_full_d  = out_full_q;
    s_axis_tready_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          op_d    = op_e'(s_axis_tuser_i);
          addr_d  = in_addr;
          if (in_plen > 7'(ADDR_BITS)) begin
            len_d = DW'(ADDR_BITS);
          end else begin
            len_d = DW'(in_plen);
          end
          dep_d   = '0;
          cur_d   = '0;
          fresh_d = 1'b0;
          best_d  = root_ent_q;
          gw_d    = in_gw;
          full_d  = 1'b0;
          state_d = ST_WALK;
        end
      end

      // Follow one existing level per cycle.
      ST_WALK: begin
        if (op_q == OP_LOOKUP) begin
          if ((cur_q != '0) && (view_ent != '0)) begin
            best_d = view_ent;
          end
          if ((dep_q == DW'(ADDR_BITS)) || (child == '0)) begin
            state_d = ST_RESULT;
          end else begin
            rd_en  = 1'b1;
            cur_d  = child;
            dep_d  = dep_q + 1'b1;
            addr_d = addr_q << 1;
          end
        end else begin
          if ((dep_q == len_q) || (child == '0)) begin
            state_d = ST_CHECK;
          end else begin
            rd_en  = 1'b1;
            cur_d  = child;
            dep_d  = dep_q + 1'b1;
            addr_d = addr_q << 1;
          end
        end
      end

      // The missing levels must all fit in the free pool.
      ST_CHECK: begin
        if (need_total > SW'(NODE_COUNT)) begin
          full_d  = 1'b1;
          state_d = ST_RESULT;
        end else begin
          state_d = ST_EXTEND;
        end
      end

      // Link one new node per cycle, then store the gateway.
      ST_EXTEND: begin
        if (dep_q != len_q) begin
          if (addr_bit) begin
            wr_data = {fresh_idx, view_kid0, view_ent};
          end else begin
            wr_data = {view_kid1, fresh_idx, view_ent};
          end
          cur_d   = fresh_idx;
          fresh_d = 1'b1;
          free_d  = free_q + 1'b1;
          dep_d   = dep_q + 1'b1;
          addr_d  = addr_q << 1;
        end else begin
          wr_data = {view_kid1, view_kid0, gw_q};
          state_d = ST_RESULT;
        end
        if (cur_q == '0) begin
          root_kid0_d = wr_data[GW_BITS +: NW];
          root_kid1_d = wr_data[GW_BITS + NW +: NW];
          root_ent_d  = wr_data[GW_BITS-1:0];
        end else begin
          wr_en = 1'b1;
        end
      end

      // Hand the result to the output register once it is free.
      ST_RESULT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load    = 1'b1;
          out_hop_d   = (op_q == OP_LOOKUP) ? best_q : '0;
          out_found_d = (op_q == OP_LOOKUP) && (best_q != '0);
          out_full_d  = (op_q == OP_INSERT) && full_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state and root node.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_q      <= FW'(1);
      root_kid0_q <= '0;
      root_kid1_q <= '0;
      root_ent_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_q      <= free_d;
      root_kid0_q <= root_kid0_d;
      root_kid1_q <= root_kid1_d;
      root_ent_q  <= root_ent_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    addr_q      <= addr_d;
    len_q       <= len_d;
    dep_q       <= dep_d;
    cur_q       <= cur_d;
    fresh_q     <= fresh_d;
    best_q      <= best_d;
    gw_q        <= gw_d;
    full_q      <= full_d;
    out_hop_q   <= out_hop_d;
    out_found_q <= out_found_d;
    out_full_q  <= out_full_d;
  end

  // Node memory write port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
  end

  // Node memory read port with registered data.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= node_mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TW - OUT_BITS){1'b0}}, out_full_q, out_found_q, out_hop_q};

  // The allocator never passes the end of the pool.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= FW'(NODE_COUNT))
    else $error("allocator ran past the node pool");

  // The root lives in flip-flops and is never written to memory.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr != '0) && (state_q == ST_EXTEND))
    else $error("node memory written outside allocation or at the root");

  // A failed insert leaves the allocator untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) && (need_total > SW'(NODE_COUNT)) |=> $stable(free_q))
    else $error("allocator moved on a full table");

  // A reported match carries a nonzero gateway and never a full flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_found_q |-> (out_hop_q != '0) && !out_full_q)
    else $error("inconsistent lookup result");

  // An accepted command starts the walk on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> (state_q == ST_WALK) && (dep_q == '0))
    else $error("walk did not start after a command transaction");

endmodule

`default_nettype wire
